### rtl/polynomial_coordinate_warp_core_macros.svh
// Assertion helpers shared by the warp core files.
// Users must have clk and rst in scope.
`ifndef POLYNOMIAL_COORDINATE_WARP_CORE_MACROS_SVH
`define POLYNOMIAL_COORDINATE_WARP_CORE_MACROS_SVH

// same-cycle implication
`define PCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pcw_pkg.sv
`default_nettype none

package pcw_pkg;

  localparam int PIXEL_BITS = 16;
  // register stages in one 64x64 multiply-shift unit
  localparam int MUL_LAT = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  typedef struct packed {
    logic               command;
    logic               coef_axis;
    logic [3:0]         coef_index;
    logic signed [63:0] coef_value;
    logic signed [31:0] easting;
    logic signed [31:0] northing;
  } item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
    logic                  clamped;
  } result_t;

endpackage

`default_nettype wire

### rtl/pcw_mul.sv
`default_nettype none
`include "polynomial_coordinate_warp_core_macros.svh"

// floor(a * b / 2^8), saturated to signed 64 bits, MUL_LAT stages.
module pcw_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               sat
);
  import pcw_pkg::*;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  logic         neg1, neg2, neg3, neg4, neg5;
  logic [63:0]  ua1, ub1;
  logic [63:0]  ll2, lh2, hl2, hh2;
  logic [63:0]  ll3, hh3;
  logic [64:0]  mid3;
  logic [127:0] full4;
  logic [120:0] mag5;
  logic [63:0]  p_next;
  logic         sat_next;

  always_comb begin
    if (!neg5) begin
      if (|mag5[120:63]) begin
        p_next   = S64_MAX;
        sat_next = 1'b1;
      end else begin
        p_next   = {1'b0, mag5[62:0]};
        sat_next = 1'b0;
      end
    end else begin
      if ((|mag5[120:64]) || (mag5[63] && (|mag5[62:0]))) begin
        p_next   = S64_MIN;
        sat_next = 1'b1;
      end else begin
        // magnitude of exactly 2^63 wraps to the minimum, as it should
        p_next   = ~mag5[63:0] + 64'd1;
        sat_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= a[63] ^ b[63];
      ua1   <= a[63] ? (~a + 64'd1) : a;
      ub1   <= b[63] ? (~b + 64'd1) : b;
      neg2  <= neg1;
      ll2   <= ua1[31:0] * ub1[31:0];
      lh2   <= ua1[31:0] * ub1[63:32];
      hl2   <= ua1[63:32] * ub1[31:0];
      hh2   <= ua1[63:32] * ub1[63:32];
      neg3  <= neg2;
      ll3   <= ll2;
      hh3   <= hh2;
      mid3  <= {1'b0, lh2} + {1'b0, hl2};
      neg4  <= neg3;
      full4 <= {hh3, ll3} + {31'b0, mid3, 32'b0};
      neg5  <= neg4;
      // floor of a negative quotient rounds the magnitude up
      mag5  <= {1'b0, full4[127:8]} + {120'b0, neg4 & (|full4[7:0])};
      p     <= p_next;
      sat   <= sat_next;
    end
  end

  `PCW_ASSERT_IMPL(a_sat_extreme, sat, (p == S64_MAX) || (p == S64_MIN), "sat without extreme")
  `PCW_ASSERT_NEXT(a_hold, !en, $stable(p) && $stable(sat), "product moved while held")
  `PCW_ASSERT_NEXT(a_zero, en && (mag5 == '0), (p == '0) && !sat, "zero magnitude not zero")

endmodule

`default_nettype wire

### rtl/polynomial_coordinate_warp_core.sv
// Pipeline: entry register, a power chain of 64x64 multiply units, the term
//   multiply units, the summing stages and the result register.
// Throughput: one item (load or transform) per cycle; the whole pipe holds
//   while a result waits under stall.
// Reset: synchronous; clears all valid bits and sets poly_order to 1.
//   Coefficient store is not cleared.
`default_nettype none
`include "polynomial_coordinate_warp_core_macros.svh"

module polynomial_coordinate_warp_core #(
  parameter int MAX_ORDER = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  pcw_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output pcw_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_data
);
  import pcw_pkg::*;

  localparam int TERMS  = 3 * MAX_ORDER;
  localparam int TIDX_W = $clog2(TERMS);
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int GROUPS = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
  localparam logic [32:0] PIX_MAX = (33'd1 << PIXEL_BITS) - 33'd1;

  typedef struct packed {
    logic                      valid;
    logic                      cmd;
    logic                      axis;
    logic [3:0]                idx;
    logic [63:0]               value;
    logic [MAX_ORDER:1][63:0]  pe;
    logic [MAX_ORDER:1][63:0]  pn;
    logic [MAX_ORDER:1][63:0]  pen;
    logic                      sat;
  } ctx_t;

  typedef struct packed {
    logic            valid;
    logic            cmd;
    logic [1:0][63:0] c0;
    logic            sat;
  } tctx_t;

  typedef struct packed {
    logic                        valid;
    logic                        cmd;
    logic [1:0][63:0]            acc;
    logic [1:0][TERMS-1:1][63:0] term;
    logic                        sat;
  } sum_t;

  function automatic logic [64:0] add_sat(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    end
    return {1'b0, s[63:0]};
  endfunction

  // {flag, pixel}: ceiling of a Q32.32 sum, clamped to the pixel range
  function automatic logic [PIXEL_BITS:0] to_pixel(input logic [63:0] acc);
    logic [32:0] ip;
    ip = {2'b0, acc[62:32]} + {32'b0, |acc[31:0]};
    if (acc[63]) begin
      // (-1, 0) rounds up to zero without a flag
      return {(acc[63:32] != 32'hFFFF_FFFF) || (acc[31:0] == 32'd0), {PIXEL_BITS{1'b0}}};
    end
    if (ip > PIX_MAX) begin
      return {1'b1, {PIXEL_BITS{1'b1}}};
    end
    return {1'b0, ip[PIXEL_BITS-1:0]};
  endfunction

  logic             en;
  logic [ORD_W-1:0] poly_order;
  logic [ORD_W-1:0] poly_order_next;
  logic [63:0]      store [2][TERMS];
  ctx_t             ctx0, ctx0_next;
  ctx_t             pw [GROUPS+1];
  ctx_t             pc;
  tctx_t            dl2 [MUL_LAT];
  logic [63:0]      tprod [2][1:TERMS-1];
  logic             tsat [2][1:TERMS-1];
  logic             ten [1:TERMS-1];
  sum_t             sm0;
  sum_t             sr [TERMS];
  logic [PIXEL_BITS:0] px_x, px_y;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  // configuration
  always_comb begin
    if (cfg_data == 3'd0) begin
      poly_order_next = ORD_W'(1);
    end else if (int'(cfg_data) > MAX_ORDER) begin
      poly_order_next = ORD_W'(MAX_ORDER);
    end else begin
      poly_order_next = ORD_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_order <= ORD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      poly_order <= poly_order_next;
    end
  end

  // entry stage
  always_comb begin
    ctx0_next        = '0;
    ctx0_next.valid  = item_valid;
    ctx0_next.cmd    = item.command;
    ctx0_next.axis   = item.coef_axis;
    ctx0_next.idx    = item.coef_index;
    ctx0_next.value  = item.coef_value;
    ctx0_next.pe[1]  = {{32{item.easting[31]}}, item.easting};
    ctx0_next.pn[1]  = {{32{item.northing[31]}}, item.northing};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx0.valid <= 1'b0;
    end else if (en) begin
      ctx0 <= ctx0_next;
    end
  end

  assign pw[0] = ctx0;

  // power chain: group g forms e^(g+1), n^(g+1) and (e*n)^g
  genvar g;
  for (g = 1; g <= GROUPS; g++) begin : g_pow
    ctx_t               dl [MUL_LAT];
    logic signed [63:0] pa, pb, pcv, opc_a, opc_b;
    logic               sa, sb, sc;

    if (g == 1) begin : g_first
      assign opc_a = pw[g-1].pe[1];
      assign opc_b = pw[g-1].pn[1];
    end else begin : g_rest
      assign opc_a = pw[g-1].pen[g-1];
      assign opc_b = pw[g-1].pen[1];
    end

    pcw_mul u_mul_e (.clk(clk), .rst(rst), .en(en), .a(pw[g-1].pe[g]),
                     .b(pw[g-1].pe[1]), .p(pa), .sat(sa));
    pcw_mul u_mul_n (.clk(clk), .rst(rst), .en(en), .a(pw[g-1].pn[g]),
                     .b(pw[g-1].pn[1]), .p(pb), .sat(sb));
    pcw_mul u_mul_en (.clk(clk), .rst(rst), .en(en), .a(opc_a), .b(opc_b),
                      .p(pcv), .sat(sc));

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int i = 0; i < MUL_LAT; i++) begin
          dl[i].valid <= 1'b0;
        end
      end else if (en) begin
        dl[0] <= pw[g-1];
        for (int i = 1; i < MUL_LAT; i++) begin
          dl[i] <= dl[i-1];
        end
      end
    end

    always_comb begin
      pw[g]        = dl[MUL_LAT-1];
      pw[g].pen[g] = pcv;
      // e*n always counts; higher cross powers only when used
      pw[g].sat    = dl[MUL_LAT-1].sat | (sc & ((g == 1) || (int'(poly_order) > g)));
      if (g + 1 <= MAX_ORDER) begin
        pw[g].pe[(g + 1 <= MAX_ORDER) ? g + 1 : 1] = pa;
        pw[g].pn[(g + 1 <= MAX_ORDER) ? g + 1 : 1] = pb;
        pw[g].sat = pw[g].sat | ((sa | sb) & (int'(poly_order) >= g + 1));
      end
    end
  end

  assign pc = pw[GROUPS];

  // coefficient store, written in item order at the term stage
  always_ff @(posedge clk) begin
    if (en && pc.valid && (pc.cmd == CMD_LOAD) && (int'(pc.idx) < TERMS)) begin
      store[pc.axis][TIDX_W'(pc.idx)] <= pc.value;
    end
  end

  // term products
  genvar ax, k;
  for (k = 1; k < TERMS; k++) begin : g_ten
    localparam int J = (k - 1) / 3 + 1;
    localparam int T = (k - 1) % 3;
    assign ten[k] = (T == 2) ? (int'(poly_order) > J) : (int'(poly_order) >= J);
  end

  for (ax = 0; ax < 2; ax++) begin : g_axis
    for (k = 1; k < TERMS; k++) begin : g_term
      localparam int J = (k - 1) / 3 + 1;
      localparam int T = (k - 1) % 3;
      logic signed [63:0] pwr;
      logic signed [63:0] prod;
      logic               psat;

      if (T == 0) begin : g_e
        assign pwr = pc.pe[J];
      end else if (T == 1) begin : g_n
        assign pwr = pc.pn[J];
      end else begin : g_en
        assign pwr = pc.pen[J];
      end

      pcw_mul u_mul (.clk(clk), .rst(rst), .en(en), .a(store[ax][k]), .b(pwr),
                     .p(prod), .sat(psat));

      assign tprod[ax][k] = prod;
      assign tsat[ax][k]  = psat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        dl2[i].valid <= 1'b0;
      end
    end else if (en) begin
      dl2[0].valid <= pc.valid;
      dl2[0].cmd   <= pc.cmd;
      dl2[0].c0[0] <= store[0][0];
      dl2[0].c0[1] <= store[1][0];
      dl2[0].sat   <= pc.sat;
      for (int i = 1; i < MUL_LAT; i++) begin
        dl2[i] <= dl2[i-1];
      end
    end
  end

  always_comb begin
    sm0       = '0;
    sm0.valid = dl2[MUL_LAT-1].valid;
    sm0.cmd   = dl2[MUL_LAT-1].cmd;
    sm0.acc   = dl2[MUL_LAT-1].c0;
    sm0.sat   = dl2[MUL_LAT-1].sat;
    for (int a = 0; a < 2; a++) begin
      for (int t = 1; t < TERMS; t++) begin
        sm0.term[a][t] = ten[t] ? tprod[a][t] : 64'd0;
        sm0.sat        = sm0.sat | (ten[t] & tsat[a][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr[0].valid <= 1'b0;
    end else if (en) begin
      sr[0] <= sm0;
    end
  end

  // saturating accumulation in layout order, one term per stage
  genvar s;
  for (s = 1; s < TERMS; s++) begin : g_sum
    sum_t        nx;
    logic [64:0] r [2];

    always_comb begin
      nx = sr[s-1];
      for (int a = 0; a < 2; a++) begin
        r[a]      = add_sat(sr[s-1].acc[a], sr[s-1].term[a][s]);
        nx.acc[a] = r[a][63:0];
        nx.sat    = nx.sat | r[a][64];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr[s].valid <= 1'b0;
      end else if (en) begin
        sr[s] <= nx;
      end
    end
  end

  assign px_x = to_pixel(sr[TERMS-1].acc[0]);
  assign px_y = to_pixel(sr[TERMS-1].acc[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sr[TERMS-1].valid && (sr[TERMS-1].cmd == CMD_XFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.pixel_x <= px_x[PIXEL_BITS-1:0];
      result.pixel_y <= px_y[PIXEL_BITS-1:0];
      result.clamped <= sr[TERMS-1].sat | px_x[PIXEL_BITS] | px_y[PIXEL_BITS];
    end
  end

  `PCW_ASSERT_IMPL(a_freeze, result_valid && result_stall, item_stall, "pipe not held on stall")
  `PCW_ASSERT_IMPL(a_order_range, 1'b1, (poly_order != '0) && (int'(poly_order) <= MAX_ORDER), "order out of range")
  `PCW_ASSERT_NEXT(a_load_silent, en && sr[TERMS-1].valid && (sr[TERMS-1].cmd == CMD_LOAD), !result_valid, "load made a result")

endmodule

`default_nettype wire

### verif/tb_polynomial_coordinate_warp_core.sv
`timescale 1ns / 1ps

module tb_polynomial_coordinate_warp_core;
  import pcw_pkg::*;

  localparam int MAX_ORDER  = 4;
  localparam int TERMS      = 3 * MAX_ORDER;
  localparam int DRAIN_WAIT = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [2:0] cfg_data = '0;

  item_t   pending_items[$];
  result_t expected_pixels[$];
  logic signed [63:0] coef_mem[2][TERMS];
  int unsigned order_shadow = 1;
  int      err_count = 0;
  int      cycle = 0;
  bit      item_taken = 1'b0;
  bit      no_idle = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_cnt = 0;

  polynomial_coordinate_warp_core #(.MAX_ORDER(MAX_ORDER)) u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(a*b / 2^8), saturated to 64 bits
  function automatic logic signed [63:0] mul_q8(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                inout bit sat);
    logic signed [127:0] p;
    p = a * b;
    p = p >>> 8;
    if (p[127:63] != {65{p[63]}}) begin
      sat = 1'b1;
      return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] add_q(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               inout bit sat);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      sat = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [PIXEL_BITS-1:0] ceil_pixel(input logic signed [63:0] acc,
                                                       inout bit sat);
    logic [32:0] ip;
    if (acc[63]) begin
      if (acc <= 64'shFFFF_FFFF_0000_0000) sat = 1'b1;
      return '0;
    end
    ip = {1'b0, acc[63:32]} + (acc[31:0] != 0);
    if (ip > (2 ** PIXEL_BITS - 1)) begin
      sat = 1'b1;
      return {PIXEL_BITS{1'b1}};
    end
    return ip[PIXEL_BITS-1:0];
  endfunction

  function automatic result_t warp_pixel(input logic signed [31:0] e32,
                                         input logic signed [31:0] n32);
    logic signed [63:0] pe[MAX_ORDER+1];
    logic signed [63:0] pn[MAX_ORDER+1];
    logic signed [63:0] pen[MAX_ORDER+1];
    logic signed [63:0] acc;
    logic [PIXEL_BITS-1:0] pix[2];
    bit sat;
    int unsigned nn;
    int unsigned k;
    result_t r;
    sat = 1'b0;
    nn = order_shadow;
    for (int j = 0; j <= MAX_ORDER; j++) begin
      pe[j] = '0; pn[j] = '0; pen[j] = '0;
    end
    pe[1] = e32;
    pn[1] = n32;
    pen[1] = mul_q8(pe[1], pn[1], sat);
    for (int j = 2; j <= nn; j++) begin
      pe[j] = mul_q8(pe[j-1], pe[1], sat);
      pn[j] = mul_q8(pn[j-1], pn[1], sat);
      if (j < nn) pen[j] = mul_q8(pen[j-1], pen[1], sat);
    end
    for (int ax = 0; ax < 2; ax++) begin
      acc = coef_mem[ax][0];
      for (int j = 1; j < nn; j++) begin
        k = 3 * (j - 1) + 1;
        acc = add_q(acc, mul_q8(coef_mem[ax][k], pe[j], sat), sat);
        acc = add_q(acc, mul_q8(coef_mem[ax][k+1], pn[j], sat), sat);
        acc = add_q(acc, mul_q8(coef_mem[ax][k+2], pen[j], sat), sat);
      end
      k = 3 * (nn - 1) + 1;
      acc = add_q(acc, mul_q8(coef_mem[ax][k], pe[nn], sat), sat);
      acc = add_q(acc, mul_q8(coef_mem[ax][k+1], pn[nn], sat), sat);
      pix[ax] = ceil_pixel(acc, sat);
    end
    r.pixel_x = pix[0];
    r.pixel_y = pix[1];
    r.clamped = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    err_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !no_idle && ($urandom_range(99) < 28);
    end
  end

  // monitor: input transactions update the predictor, results are checked
  always @(posedge clk) begin
    result_t want;
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("polynomial_coordinate_warp_core test failed");
      $finish;
    end
    item_taken = !rst && item_valid && !item_stall;
    if (item_taken) begin
      if (item.command == CMD_XFORM)
        expected_pixels.push_back(warp_pixel(item.easting, item.northing));
      else if (item.coef_index < TERMS)
        coef_mem[item.coef_axis][item.coef_index] = item.coef_value;
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (result.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", result.pixel_x, want.pixel_x);
        if (result.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", result.pixel_y, want.pixel_y);
        if (result.clamped !== want.clamped)
          report_mismatch("clamped", result.clamped, want.clamped);
      end
    end
  end

  function automatic item_t load_item(input bit axis, input logic [3:0] idx,
                                      input logic signed [63:0] v);
    item_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.coef_axis = axis;
    it.coef_index = idx;
    it.coef_value = v;
    it.easting = $urandom;
    it.northing = $urandom;
    return it;
  endfunction

  function automatic item_t xform_item(input logic signed [31:0] e,
                                       input logic signed [31:0] n);
    item_t it;
    it = '0;
    it.command = CMD_XFORM;
    it.coef_axis = 1'($urandom);
    it.coef_index = 4'($urandom);
    it.coef_value = {$urandom, $urandom};
    it.easting = e;
    it.northing = n;
    return it;
  endfunction

  function automatic logic signed [63:0] rand_coef(input int k);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return v;
      1: return 64'($urandom_range(70000)) << 32 | 64'($urandom);
      default: begin
        if (k == 0) return 64'($urandom_range(60000)) << 32 | 64'($urandom);
        return v >>> $urandom_range(20, 62);
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(9) == 0) return v;
    return v >>> $urandom_range(8, 31);
  endfunction

  task automatic wait_drain();
    while (pending_items.size() > 0 || item_valid) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_order(input logic [2:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (v == 0) order_shadow = 1;
    else if (v > MAX_ORDER) order_shadow = MAX_ORDER;
    else order_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all_random();
    for (int ax = 0; ax < 2; ax++)
      for (int k = 0; k < TERMS; k++)
        pending_items.push_back(load_item(1'(ax), 4'(k), rand_coef(k)));
  endtask

  initial begin
    logic [2:0] orders[8];
    item_t it;
    orders = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: sane X polynomial, extreme Y polynomial
    for (int k = 0; k < TERMS; k++) begin
      pending_items.push_back(load_item(1'b0, 4'(k), (k == 0) ? 64'sh64_0000_0001 :
                                               (k == 1) ? 64'sh1_0000_0000 : 64'sh100));
      pending_items.push_back(load_item(1'b1, 4'(k), (k % 2) ? 64'sh7FFF_FFFF_FFFF_FFFF :
                                                        64'sh8000_0000_0000_0000));
    end
    // index past the store is dropped
    pending_items.push_back(load_item(1'b0, 4'd15, 64'sh7FFF_FFFF_FFFF_FFFF));
    pending_items.push_back(load_item(1'b1, 4'd12, 64'sh8000_0000_0000_0000));
    pending_items.push_back(xform_item(0, 0));
    pending_items.push_back(xform_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_items.push_back(xform_item(32'sh8000_0000, 32'sh8000_0000));
    pending_items.push_back(xform_item(1, -1));
    pending_items.push_back(xform_item(256, -512));
    pending_items.push_back(xform_item(32'sh7FFF_FFFF, 32'sh8000_0000));
    wait_drain();

    // random phases across orders; a long no-idle stretch and a receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      write_order(orders[ph]);
      load_all_random();
      pending_items.push_back(xform_item(0, 0));
      no_idle = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(9) < 8) begin
          pending_items.push_back(xform_item(rand_coord(), rand_coord()));
        end else begin
          it = load_item(1'($urandom), 4'($urandom_range(15)),
                         rand_coef($urandom_range(11)));
          pending_items.push_back(it);
        end
      end
      wait_drain();
      no_idle = 1'b0;
    end

    if (err_count == 0)
      $display("polynomial_coordinate_warp_core test passed");
    else
      $display("polynomial_coordinate_warp_core test failed");
    $finish;
  end

endmodule
